// File: sv/eiec_pkg.sv
// shared constants, types and helpers for the external interrupt edge controller
package eiec_pkg;

  // sizing
  localparam int LINE_COUNT  = 16;
  localparam int PORT_COUNT  = 4;
  localparam int LINE_W      = 16;
  localparam int SEL_W       = 4;
  localparam int PSEL_W      = 62;
  localparam int IRQ_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = PSEL_W;

  // lines that exist, the rest read as zero
  localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'((32'd1 << LINE_COUNT) - 32'd1);

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PORT_SELECT    = 2'd0,
    REG_RISING_ENABLE  = 2'd1,
    REG_FALLING_ENABLE = 2'd2,
    REG_IRQ_ENABLE     = 2'd3
  } cfg_reg_e;

  // what an input word asks for
  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

  // port selector codes
  localparam logic [SEL_W-1:0] SEL_PORT_A = 4'd0;

  // configuration seen by the datapath
  typedef struct packed {
    logic [PSEL_W-1:0] port_select;
    logic [LINE_W-1:0] rising_enable;
    logic [LINE_W-1:0] falling_enable;
    logic [LINE_W-1:0] irq_enable;
  } eiec_cfg_t;

  // result of one word, from the edge stage to the output register
  typedef struct packed {
    logic [LINE_W-1:0] pending_bits;
    logic [IRQ_W-1:0]  irq_outputs;
  } eiec_res_t;

  // fold enabled pending lines onto the seven interrupt outputs
  function automatic logic [IRQ_W-1:0] irq_map(input logic [LINE_W-1:0] active);
    logic [IRQ_W-1:0] res;
    res      = '0;
    res[4:0] = active[4:0];
    res[5]   = |active[9:5];
    res[6]   = |active[15:10];
    return res;
  endfunction

endpackage

// File: sv/eiec_if.sv
// stream interfaces for sample/clear words and result words

// input channel: action, port levels and clear mask
interface eiec_in_if;
  import eiec_pkg::*;
  logic              valid;
  logic              ready;
  action_e           action;
  logic [LINE_W-1:0] port_a_levels;
  logic [LINE_W-1:0] port_b_levels;
  logic [LINE_W-1:0] port_c_levels;
  logic [LINE_W-1:0] port_d_levels;
  logic [LINE_W-1:0] clear_bits;

  modport source (
    output valid, action, port_a_levels, port_b_levels, port_c_levels,
           port_d_levels, clear_bits,
    input  ready
  );
  modport sink (
    input  valid, action, port_a_levels, port_b_levels, port_c_levels,
           port_d_levels, clear_bits,
    output ready
  );
endinterface

// output channel: pending flags and interrupt lines
interface eiec_out_if;
  import eiec_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] pending_bits;
  logic [IRQ_W-1:0]  irq_outputs;

  modport source (
    output valid, pending_bits, irq_outputs,
    input  ready
  );
  modport sink (
    input  valid, pending_bits, irq_outputs,
    output ready
  );
endinterface

// File: sv/external_interrupt_edge_controller.sv
// top level: sixteen-line external interrupt edge controller
// result: the result word of an accepted word is registered and valid in the cycle after acceptance
// throughput: one word per cycle, limited only by the result register draining
// the pending and last-level state updates at the same edge that loads the result
// reset: asynchronous active low, clears configuration, state and result valid
module external_interrupt_edge_controller import eiec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  eiec_in_if.sink               in_i,
  eiec_out_if.source            out_o
);

  eiec_cfg_t         cfg;
  eiec_res_t         res_next;
  eiec_res_t         res_reg;
  logic              free;
  logic              accept;
  logic [LINE_W-1:0] pending;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  // configuration registers
  eiec_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // edge detection and pending state
  eiec_edge u_edge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .accept_i     (accept),
    .action_i     (in_i.action),
    .port_a_i     (in_i.port_a_levels),
    .port_b_i     (in_i.port_b_levels),
    .port_c_i     (in_i.port_c_levels),
    .port_d_i     (in_i.port_d_levels),
    .clear_bits_i (in_i.clear_bits),
    .res_o        (res_next),
    .pending_o    (pending)
  );

  // result register
  eiec_outreg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_next),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .res_o       (res_reg),
    .free_o      (free)
  );

  assign out_o.pending_bits = res_reg.pending_bits;
  assign out_o.irq_outputs  = res_reg.irq_outputs;

`ifndef SYNTHESIS
  // every accepted word shows up as a result next cycle
  a_accept_to_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("accepted word produced no result");

  // a clear word leaves none of its named bits pending
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.action == ACT_CLEAR |=>
      (out_o.pending_bits & $past(in_i.clear_bits)) == '0)
    else $error("clear word left a bit pending");

  // a sample word never drops a pending bit
  a_sample_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.action == ACT_SAMPLE |=>
      (out_o.pending_bits & $past(pending)) == $past(pending))
    else $error("sample word dropped a pending bit");

  // the result matches the pending state it was taken from
  a_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.pending_bits == pending)
    else $error("result differs from pending state");
`endif

endmodule

// File: sv/eiec_cfg.sv
// configuration registers written through the plain write port
module eiec_cfg import eiec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output eiec_cfg_t             cfg_o
);

  eiec_cfg_t cfg_q, cfg_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PORT_SELECT:    cfg_d.port_select    = cfg_wdata_i[PSEL_W-1:0];
        REG_RISING_ENABLE:  cfg_d.rising_enable  = cfg_wdata_i[LINE_W-1:0];
        REG_FALLING_ENABLE: cfg_d.falling_enable = cfg_wdata_i[LINE_W-1:0];
        REG_IRQ_ENABLE:     cfg_d.irq_enable     = cfg_wdata_i[LINE_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/eiec_edge.sv
// line routing, edge detection and pending flag state
module eiec_edge import eiec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eiec_cfg_t         cfg_i,
  input  logic              accept_i,
  input  action_e           action_i,
  input  logic [LINE_W-1:0] port_a_i,
  input  logic [LINE_W-1:0] port_b_i,
  input  logic [LINE_W-1:0] port_c_i,
  input  logic [LINE_W-1:0] port_d_i,
  input  logic [LINE_W-1:0] clear_bits_i,
  output eiec_res_t         res_o,
  output logic [LINE_W-1:0] pending_o
);

  logic [LINE_W-1:0] last_q, last_d;
  logic [LINE_W-1:0] pend_q, pend_d;
  logic [LINE_W-1:0] cur;
  logic [LINE_W-1:0] rise, fall;
  logic [SEL_W*LINE_W-1:0] sel_all;
  logic [LINE_W-1:0] ports [PORT_COUNT];

  assign sel_all  = {(SEL_W*LINE_W-PSEL_W)'(0), cfg_i.port_select};
  assign ports[0] = port_a_i;
  assign ports[1] = port_b_i;
  assign ports[2] = port_c_i;
  assign ports[3] = port_d_i;

  // route each line from its selected port, unknown selectors fall back to port a
  always_comb begin
    logic [SEL_W-1:0] sel;
    cur = '0;
    for (int l = 0; l < LINE_W; l++) begin
      sel = sel_all[SEL_W*l +: SEL_W];
      if (int'(sel) >= PORT_COUNT) begin
        sel = SEL_PORT_A;
      end
      cur[l] = ports[sel[1:0]][l];
    end
    cur = cur & LINE_MASK;
  end

  // edge detect and pending update
  assign rise = cur & ~last_q & cfg_i.rising_enable;
  assign fall = ~cur & last_q & cfg_i.falling_enable;

  always_comb begin
    last_d = last_q;
    pend_d = pend_q;
    case (action_i)
      ACT_SAMPLE: begin
        pend_d = (pend_q | rise | fall) & LINE_MASK;
        last_d = cur;
      end
      ACT_CLEAR: begin
        pend_d = pend_q & ~clear_bits_i & LINE_MASK;
      end
      default: begin
        pend_d = pend_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      pend_q <= '0;
    end else if (accept_i) begin
      last_q <= last_d;
      pend_q <= pend_d;
    end
  end

  // result of this word
  assign res_o.pending_bits = pend_d;
  assign res_o.irq_outputs  = irq_map(pend_d & cfg_i.irq_enable & LINE_MASK);
  assign pending_o          = pend_q;

endmodule

// File: sv/eiec_outreg.sv
// result register with valid, decouples the input from a stalled sink
module eiec_outreg import eiec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  eiec_res_t res_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output eiec_res_t res_o,
  output logic      free_o
);

  logic      valid_q, valid_d;
  eiec_res_t res_q;

  // free when empty or the word leaves this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
